@@ hdl/dmsl_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsl_pkg
// Shared types, constants and helper functions for the dual motor slew limiter.
// ----------------------------------------------------------------------------
package dmsl_pkg;

  // Request codes carried in req_type
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Speed limits, percent
  localparam logic signed [15:0] TARGET_MAX = 16'sd100;
  localparam logic signed [15:0] TARGET_MIN = -16'sd100;
  localparam logic signed [7:0]  SPEED_MAX  = 8'sd100;
  localparam logic signed [7:0]  SPEED_MIN  = -8'sd100;

  // Duty scaling
  localparam logic [10:0] DUTY_CAP = 11'd999;

  // Ramp step after reset
  localparam logic [7:0] RAMP_RESET = 8'd20;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] left_target;
    logic signed [15:0] right_target;
    logic               bypass;
  } cmd_t;

  typedef struct packed {
    logic       left_pin_a;
    logic       left_pin_b;
    logic [9:0] left_duty;
    logic       right_pin_a;
    logic       right_pin_b;
    logic [9:0] right_duty;
  } drv_t;

  // Per-channel bridge drive
  typedef struct packed {
    logic       pin_a;
    logic       pin_b;
    logic [9:0] duty;
  } bridge_t;

  // Per-channel update strobes
  typedef struct packed {
    logic load_goal;
    logic apply;
    logic tick;
  } chan_ctl_t;

  // Saturate a requested speed to -100..100
  function automatic logic signed [7:0] clamp_speed(input logic signed [15:0] t);
    logic signed [7:0] r;
    if (t > TARGET_MAX) begin
      r = SPEED_MAX;
    end else if (t < TARGET_MIN) begin
      r = SPEED_MIN;
    end else begin
      r = t[7:0];
    end
    return r;
  endfunction

  // One ramp step toward the goal, landing on the goal instead of passing it
  function automatic logic signed [7:0] ramp_toward(input logic signed [7:0] cur,
                                                    input logic signed [7:0] goal,
                                                    input logic [7:0]        step);
    logic signed [10:0] cur_w;
    logic signed [10:0] goal_w;
    logic signed [10:0] step_w;
    logic signed [10:0] up;
    logic signed [10:0] dn;
    logic signed [7:0]  r;
    cur_w  = {{3{cur[7]}}, cur};
    goal_w = {{3{goal[7]}}, goal};
    step_w = {3'b000, step};
    up     = cur_w + step_w;
    dn     = cur_w - step_w;
    if (cur < goal) begin
      r = (up > goal_w) ? goal : up[7:0];
    end else if (cur > goal) begin
      r = (dn < goal_w) ? goal : dn[7:0];
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // Bridge pins and duty for a speed in -100..100
  function automatic bridge_t drive(input logic signed [7:0] speed);
    bridge_t     b;
    logic [6:0]  mag;
    logic [10:0] duty_w;
    logic [7:0]  neg;
    neg = 8'(-speed);
    if (speed > 8'sd0) begin
      b.pin_a = 1'b1;
      b.pin_b = 1'b0;
      mag     = speed[6:0];
    end else if (speed < 8'sd0) begin
      b.pin_a = 1'b0;
      b.pin_b = 1'b1;
      mag     = neg[6:0];
    end else begin
      b.pin_a = 1'b1;
      b.pin_b = 1'b1;
      mag     = 7'd0;
    end
    // x10 as x8 + x2
    duty_w = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
    if (duty_w > DUTY_CAP) begin
      duty_w = DUTY_CAP;
    end
    b.duty = duty_w[9:0];
    return b;
  endfunction

endpackage

@@ hdl/dual_motor_slew_limiter.sv @@
// ----------------------------------------------------------------------------
// dual_motor_slew_limiter
// Two-channel motor speed ramp with H-bridge pin and PWM duty outputs.
// ----------------------------------------------------------------------------
// Takes one request transfer per clock while cmd_stall is low. A request
// is held in an input register, then updates the speed state and, if it
// produces a result, loads the result register, which presents it on drv
// until it transfers at an edge with drv_stall low. A speed command
// (req_type 0) clamps both targets to -100..100 and stores them as goals;
// with bypass set it also copies them to the current speeds and produces a
// result. A tick (req_type 1) moves each current speed toward its goal by the
// ramp step without overshooting and always produces a result. Pins per
// channel: A=1,B=0 forward, A=0,B=1 reverse, A=1,B=1 brake at zero speed;
// duty is |speed|*10 capped at 999. The result register holds one result;
// while it is full and stalled, the input register holds a result-producing
// request and cmd_stall rises, so throughput is one request per cycle
// whenever drv_stall stays low. The ramp step is written on the cfg channel,
// which is always ready; write it only while the block is idle.
module dual_motor_slew_limiter import dmsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  cmd_t       cmd,
  // result channel
  output logic       drv_valid,
  input  logic       drv_stall,
  output drv_t       drv,
  // configuration write channel (ramp step)
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] step_size;

  // input register
  logic       s1_valid;
  logic       s1_valid_next;
  cmd_t       s1;
  logic       s1_result;   // request in s1 produces a result
  logic       s1_go;       // s1 request retires this cycle
  logic       cmd_xfer;

  logic       drv_valid_next;
  logic       drv_load;

  chan_ctl_t  ctl;
  bridge_t    left_bridge;
  bridge_t    right_bridge;

  // Configuration: always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= RAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_size <= cfg_data;
    end
  end

  // A request without a result retires regardless of the output side;
  // one with a result waits for the result register to free up.
  assign s1_result = (s1.req_type == REQ_TICK) || s1.bypass;
  assign s1_go     = s1_valid && (!s1_result || !drv_valid || !drv_stall);
  assign cmd_stall = s1_valid && !s1_go;
  assign cmd_xfer  = cmd_valid && !cmd_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (cmd_xfer) begin
      s1_valid_next = 1'b1;
    end else if (s1_go) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      s1 <= cmd;
    end
  end

  // Channel update strobes
  assign ctl.load_goal = s1_go && (s1.req_type == REQ_CMD);
  assign ctl.apply     = s1_go && (s1.req_type == REQ_CMD) && s1.bypass;
  assign ctl.tick      = s1_go && (s1.req_type == REQ_TICK);

  dmsl_channel u_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .target (s1.left_target),
    .step   (step_size),
    .bridge (left_bridge)
  );

  dmsl_channel u_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .target (s1.right_target),
    .step   (step_size),
    .bridge (right_bridge)
  );

  // Result register
  assign drv_load       = s1_go && s1_result;
  assign drv_valid_next = (drv_valid && drv_stall) || drv_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      drv_valid <= drv_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (drv_load) begin
      drv.left_pin_a  <= left_bridge.pin_a;
      drv.left_pin_b  <= left_bridge.pin_b;
      drv.left_duty   <= left_bridge.duty;
      drv.right_pin_a <= right_bridge.pin_a;
      drv.right_pin_b <= right_bridge.pin_b;
      drv.right_duty  <= right_bridge.duty;
    end
  end

  // A retiring tick always leaves a result behind
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1.req_type == REQ_TICK)) |=> drv_valid)
    else $error("tick retired without result");

  // Zero duty exactly when the bridge is braked
  a_left_brake: assert property (@(posedge clk) disable iff (rst)
    drv_valid |-> ((drv.left_duty == 10'd0) == (drv.left_pin_a && drv.left_pin_b)))
    else $error("left duty and brake disagree");

  a_right_brake: assert property (@(posedge clk) disable iff (rst)
    drv_valid |-> ((drv.right_duty == 10'd0) == (drv.right_pin_a && drv.right_pin_b)))
    else $error("right duty and brake disagree");

  // Backpressure only while a result-producing request is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (s1_valid && s1_result && drv_valid && drv_stall))
    else $error("request stalled without cause");

endmodule

@@ hdl/dmsl_channel.sv @@
// ----------------------------------------------------------------------------
// dmsl_channel
// One motor channel: goal and current speed registers, ramp, bridge drive.
// ----------------------------------------------------------------------------
module dmsl_channel import dmsl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  chan_ctl_t          ctl,
  input  logic signed [15:0] target,
  input  logic [7:0]         step,
  output bridge_t            bridge
);

  logic signed [7:0] goal;
  logic signed [7:0] goal_next;
  logic signed [7:0] current;
  logic signed [7:0] current_next;
  logic signed [7:0] target_sat;

  assign target_sat = clamp_speed(target);

  always_comb begin
    goal_next    = goal;
    current_next = current;
    if (ctl.load_goal) begin
      goal_next = target_sat;
    end
    if (ctl.apply) begin
      current_next = target_sat;
    end else if (ctl.tick) begin
      current_next = ramp_toward(current, goal, step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal    <= '0;
      current <= '0;
    end else begin
      goal    <= goal_next;
      current <= current_next;
    end
  end

  // drive reflects the speed after this cycle's update
  assign bridge = drive(current_next);

  a_current_range: assert property (@(posedge clk) disable iff (rst)
    (current <= SPEED_MAX) && (current >= SPEED_MIN))
    else $error("current speed out of range");

  a_goal_range: assert property (@(posedge clk) disable iff (rst)
    (goal <= SPEED_MAX) && (goal >= SPEED_MIN))
    else $error("goal speed out of range");

  a_apply_lands: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |=> (current == goal))
    else $error("bypass did not set current to goal");

endmodule
